>>> sv/hslj_pkg.sv
// Shared widths, register codes and fixed-point helpers for the HSL color jitter core.
// No dependencies; imported by hslj_div, hsl_color_jitter_core and the testbench.
`timescale 1ns / 1ps

package hslj_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_W     = FRAC_BITS + 1;
  localparam logic [ONE_W-1:0] ONE  = ONE_W'(1) << FRAC_BITS;
  localparam logic [ONE_W-1:0] HALF = ONE >> 1;

  localparam int CH_W      = 8;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HUE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT = 2'd2;

  // divider: divisor up to 6*255, quotient at most ONE
  localparam int DIV_DW = 11;
  localparam int DIV_QW = FRAC_BITS + 1;
  localparam int DIV_NW = FRAC_BITS + DIV_DW;

  localparam int OFF_SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int OFF_SHR = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam int OFF_W   = CFG_W + OFF_SHL;
  localparam int SUM_W   = ((OFF_W > ONE_W) ? OFF_W : ONE_W) + 2;

  // Q16 offset to FRAC_BITS, floor on a right shift
  function automatic logic signed [OFF_W-1:0] off_to_frac(input logic [CFG_W-1:0] off);
    logic signed [OFF_W-1:0] ext;
    ext = OFF_W'($signed(off));
    return (ext <<< OFF_SHL) >>> OFF_SHR;
  endfunction

  function automatic logic [ONE_W-1:0] clamp_one(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] one_s;
    one_s = $signed({{(SUM_W-ONE_W){1'b0}}, ONE});
    if (v[SUM_W-1]) begin
      return '0;
    end else if (v > one_s) begin
      return ONE;
    end
    return v[ONE_W-1:0];
  endfunction

endpackage

>>> sv/hslj_div.sv
// Pipelined restoring divider, one quotient bit per stage, stall by enable.
// Depends on hslj_pkg for the dividend, divisor and quotient widths.
`timescale 1ns / 1ps

module hslj_div import hslj_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DIV_NW-1:0] dividend_i,
  input  logic [DIV_DW-1:0] divisor_i,
  output logic [DIV_QW-1:0] quotient_o
);

  logic [DIV_NW-1:0] rem_q [DIV_QW];
  logic [DIV_DW-1:0] den_q [DIV_QW];
  logic [DIV_QW-1:0] quo_q [DIV_QW];

  for (genvar i = 0; i < DIV_QW; i++) begin : g_stage
    logic [DIV_NW-1:0] rem_in;
    logic [DIV_NW-1:0] sub;
    logic [DIV_DW-1:0] den_in;
    logic [DIV_QW-1:0] quo_in;
    logic              fit;

    if (i == 0) begin : g_first
      assign rem_in = dividend_i;
      assign den_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign sub = DIV_NW'(den_in) << (DIV_QW - 1 - i);
    assign fit = (rem_in >= sub);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= fit ? rem_in - sub : rem_in;
        den_q[i] <= den_in;
        quo_q[i] <= {quo_in[DIV_QW-2:0], fit};
      end
    end
  end

  assign quotient_o = quo_q[DIV_QW-1];

endmodule

>>> sv/hsl_color_jitter_core.sv
// Top level of the HSL color jitter: RGB to HSL, offset, HSL back to RGB.
// Depends on hslj_pkg and hslj_div.
`timescale 1ns / 1ps

// Usage
//   Pixel in:  in_valid_i / in_ready_o with red_in_i, green_in_i, blue_in_i, last_pixel_i.
//   Pixel out: out_valid_o / out_ready_i with red_out_o, green_out_o, blue_out_o, last_out_o.
//   Config:    cfg_valid_i / cfg_ready_o, cfg_index_i selects hue (0), saturation (1)
//              or lightness (2) offset, cfg_data_i is the signed Q16 value; index 3 is
//              dropped. cfg_ready_o is always high. Write only while the pipe is empty.
// Throughput: one pixel per clock, sustained while the output is not stalled.
// Pipeline, from input beat to output beat: input register, min/max stage,
//   FRAC_BITS+1 divider stages (hue and saturation dividers run side by side;
//   lightness is a reciprocal multiply held in a matching delay line), offset
//   stage, lightness*saturation multiply, ramp select, ramp multiply, and the
//   byte-scaling output register.
// Stall: the whole pipe advances only when the output register is empty or its beat
//   is taken, so in_ready_o follows out_ready_i; no beat is lost or repeated.
// Reset: all valid bits and offsets clear; offsets read zero until written.
module hsl_color_jitter_core import hslj_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CH_W-1:0]      red_in_i,
  input  logic [CH_W-1:0]      green_in_i,
  input  logic [CH_W-1:0]      blue_in_i,
  input  logic                 last_pixel_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CH_W-1:0]      red_out_o,
  output logic [CH_W-1:0]      green_out_o,
  output logic [CH_W-1:0]      blue_out_o,
  output logic                 last_out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int H3_W = FRAC_BITS + 2;
  localparam int P_W  = ONE_W + 2;
  localparam int D_W  = ONE_W + 1;

  logic en;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] hue_off_q, sat_off_q, light_off_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_off_q   <= '0;
      sat_off_q   <= '0;
      light_off_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HUE:   hue_off_q   <= cfg_data_i;
        CFG_SAT:   sat_off_q   <= cfg_data_i;
        CFG_LIGHT: light_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ valid/last chain
  logic              out_valid_q;
  logic              v0_q, v1_q, vb_q, vc_q, vd_q, ve_q;
  logic              l0_q, l1_q, lb_q, lc_q, ld_q, le_q, last_q;
  logic [DIV_QW-1:0] dv_q, dl_q;

  // advance when the output slot is free or being emptied
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign last_out_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; dv_q <= '0;
      vb_q <= 1'b0; vc_q <= 1'b0; vd_q <= 1'b0; ve_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      dv_q <= {dv_q[DIV_QW-2:0], v1_q};
      vb_q <= dv_q[DIV_QW-1];
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      out_valid_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l0_q   <= last_pixel_i;
      l1_q   <= l0_q;
      dl_q   <= {dl_q[DIV_QW-2:0], l1_q};
      lb_q   <= dl_q[DIV_QW-1];
      lc_q   <= lb_q;
      ld_q   <= lc_q;
      le_q   <= ld_q;
      last_q <= le_q;
    end
  end

  // ------------------------------------------------------- input register
  logic [CH_W-1:0] r0_q, g0_q, b0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r0_q <= red_in_i;
      g0_q <= green_in_i;
      b0_q <= blue_in_i;
    end
  end

  // --------------------------------------- max/min and hue sector numerator
  logic [CH_W-1:0]   mx, mn, mx_rg, mn_rg;
  logic [11:0]       num;
  logic [CH_W-1:0]   d1_q;
  logic [CH_W:0]     sum1_q;
  logic [DIV_DW-1:0] num1_q;

  always_comb begin
    mx_rg = (r0_q > g0_q) ? r0_q : g0_q;
    mn_rg = (r0_q < g0_q) ? r0_q : g0_q;
    mx    = (mx_rg > b0_q) ? mx_rg : b0_q;
    mn    = (mn_rg < b0_q) ? mn_rg : b0_q;
    if (mx == r0_q) begin
      if (g0_q >= b0_q) begin
        num = 12'(g0_q) - 12'(b0_q);
      end else begin
        num = 12'(6) * 12'(mx - mn) - (12'(b0_q) - 12'(g0_q));
      end
    end else if (mx == g0_q) begin
      num = 12'(2) * 12'(mx - mn) + 12'(b0_q) - 12'(r0_q);
    end else begin
      num = 12'(4) * 12'(mx - mn) + 12'(r0_q) - 12'(g0_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q   <= mx - mn;
      sum1_q <= {1'b0, mx} + {1'b0, mn};
      num1_q <= num[DIV_DW-1:0];
    end
  end

  // ------------------------------------------------------ divider operands
  logic [CH_W:0]     den_s;
  logic [DIV_NW-1:0] s_num, h_num;
  logic [DIV_DW-1:0] s_den, h_den;
  logic [DIV_QW-1:0] s_quo, h_quo, l_quo;

  always_comb begin
    den_s = (sum1_q <= 9'd255) ? sum1_q : 9'd510 - sum1_q;
    // gray pixel: force zero quotient, keep divisor nonzero
    if (d1_q == '0) begin
      s_num = '0;
      s_den = DIV_DW'(1);
      h_num = '0;
      h_den = DIV_DW'(1);
    end else begin
      s_num = (DIV_NW'(d1_q) << FRAC_BITS) + DIV_NW'(den_s >> 1);
      s_den = DIV_DW'(den_s);
      h_num = (DIV_NW'(num1_q) << FRAC_BITS) + DIV_NW'(3) * DIV_NW'(d1_q);
      h_den = DIV_DW'(6) * DIV_DW'(d1_q);
    end
  end

  hslj_div u_div_s (.clk_i, .en_i(en), .dividend_i(s_num), .divisor_i(s_den),
                    .quotient_o(s_quo));
  hslj_div u_div_h (.clk_i, .en_i(en), .dividend_i(h_num), .divisor_i(h_den),
                    .quotient_o(h_quo));

  // ------------------------------------------- lightness, divide by 510
  // (sum*ONE + 255) / 510 equals (sum*ONE/2 + 127) / 255; divide by 255 with a
  // reciprocal multiply, exact for every sum, then delay to line up with the dividers.
  localparam int LY_W = FRAC_BITS + 8;
  localparam int LM_W = FRAC_BITS + 9;
  localparam int LP_W = LY_W + LM_W;
  localparam int L_SH = FRAC_BITS + 16;
  localparam logic [LM_W-1:0] L_RECIP = LM_W'(((longint'(1) <<< L_SH) + 254) / 255);

  logic [LY_W-1:0]  l_y;
  logic [LP_W-1:0]  l_prod;
  logic [ONE_W-1:0] l_calc;
  logic [ONE_W-1:0] l_dly_q [DIV_QW];

  always_comb begin
    l_y    = (LY_W'(sum1_q) << (FRAC_BITS - 1)) + LY_W'(127);
    l_prod = LP_W'(l_y) * LP_W'(L_RECIP);
    l_calc = l_prod[L_SH +: ONE_W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_dly_q[0] <= l_calc;
      for (int i = 1; i < DIV_QW; i++) begin
        l_dly_q[i] <= l_dly_q[i-1];
      end
    end
  end

  assign l_quo = l_dly_q[DIV_QW-1];

  // ------------------------------------------------------------- offsets
  logic signed [SUM_W-1:0] h_sum, s_sum, l_sum;
  logic [FRAC_BITS-1:0]    hb_q;
  logic [ONE_W-1:0]        sb_q, lb2_q;

  always_comb begin
    h_sum = $signed({{(SUM_W-DIV_QW){1'b0}}, h_quo}) + SUM_W'(off_to_frac(hue_off_q));
    s_sum = $signed({{(SUM_W-DIV_QW){1'b0}}, s_quo}) + SUM_W'(off_to_frac(sat_off_q));
    l_sum = $signed({{(SUM_W-DIV_QW){1'b0}}, l_quo}) + SUM_W'(off_to_frac(light_off_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hb_q  <= h_sum[FRAC_BITS-1:0];   // wrap modulo one
      sb_q  <= clamp_one(s_sum);
      lb2_q <= clamp_one(l_sum);
    end
  end

  // ------------------------------------- l*s and hue positions in thirds
  logic [2*ONE_W-1:0] ls_prod;
  logic [H3_W-1:0]    h3;
  logic [ONE_W-1:0]   lsc_q, lc2_q, sc_q;
  logic [H3_W-1:0]    trc_q, tgc_q, tbc_q;

  always_comb begin
    ls_prod = lb2_q * sb_q + (2*ONE_W)'(HALF);
    h3      = H3_W'(3) * H3_W'(hb_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lsc_q <= ls_prod[FRAC_BITS +: ONE_W];
      lc2_q <= lb2_q;
      sc_q  <= sb_q;
      tgc_q <= h3;
      trc_q <= (h3 + H3_W'(ONE) >= H3_W'(3) * H3_W'(ONE)) ?
               h3 - H3_W'(2) * H3_W'(ONE) : h3 + H3_W'(ONE);
      tbc_q <= (h3 < H3_W'(ONE)) ? h3 + H3_W'(2) * H3_W'(ONE) : h3 - H3_W'(ONE);
    end
  end

  // ------------------------------------------------ q, p and ramp factors
  // Flat segments use factor one (gives q) or zero (gives p).
  function automatic logic [ONE_W-1:0] ramp_factor(input logic [H3_W-1:0] t3);
    logic [H3_W:0] t2;
    t2 = {t3, 1'b0};
    if (t2 < (H3_W+1)'(ONE)) begin
      return t2[ONE_W-1:0];
    end else if (t2 < (H3_W+1)'(3) * (H3_W+1)'(ONE)) begin
      return ONE;
    end else if (t3 < H3_W'(2) * H3_W'(ONE)) begin
      return ONE_W'((H3_W+1)'(4) * (H3_W+1)'(ONE) - t2);
    end
    return '0;
  endfunction

  logic [D_W-1:0]        qv;
  logic signed [P_W-1:0] pd_q;
  logic [D_W-1:0]        diffd_q;
  logic [ONE_W-1:0]      fr_q, fg_q, fb_q;

  always_comb begin
    qv = (lc2_q < HALF) ? D_W'(lc2_q) + D_W'(lsc_q)
                        : D_W'(lc2_q) + D_W'(sc_q) - D_W'(lsc_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd_q    <= $signed(P_W'(lc2_q) << 1) - $signed(P_W'(qv));
      diffd_q <= D_W'((P_W'(qv) << 1) - (P_W'(lc2_q) << 1));
      fr_q    <= ramp_factor(trc_q);
      fg_q    <= ramp_factor(tgc_q);
      fb_q    <= ramp_factor(tbc_q);
    end
  end

  // ------------------------------------------------------- ramp multiply
  localparam int PR_W = D_W + ONE_W;

  function automatic logic signed [SUM_W-1:0] ramp_val(input logic signed [P_W-1:0] p,
                                                       input logic [D_W-1:0] diff,
                                                       input logic [ONE_W-1:0] f);
    logic [PR_W-1:0] prod;
    prod = PR_W'(diff) * PR_W'(f) + PR_W'(HALF);
    return SUM_W'(p) + $signed(SUM_W'(prod >> FRAC_BITS));
  endfunction

  logic signed [SUM_W-1:0] ve_r_q, ve_g_q, ve_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ve_r_q <= ramp_val(pd_q, diffd_q, fr_q);
      ve_g_q <= ramp_val(pd_q, diffd_q, fg_q);
      ve_b_q <= ramp_val(pd_q, diffd_q, fb_q);
    end
  end

  // ------------------------------------------------ scale to byte, output
  localparam int BY_W = ONE_W + CH_W;

  function automatic logic [CH_W-1:0] to_byte(input logic signed [SUM_W-1:0] v);
    logic [BY_W-1:0] acc;
    logic [BY_W-1:0] res;
    acc = BY_W'(clamp_one(v)) * BY_W'(255) + BY_W'(HALF);
    res = acc >> FRAC_BITS;
    return (res > BY_W'(255)) ? CH_W'(255) : res[CH_W-1:0];
  endfunction

  logic [CH_W-1:0] ro_q, go_q, bo_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ro_q <= to_byte(ve_r_q);
      go_q <= to_byte(ve_g_q);
      bo_q <= to_byte(ve_b_q);
    end
  end

  assign red_out_o   = ro_q;
  assign green_out_o = go_q;
  assign blue_out_o  = bo_q;

endmodule

>>> bench/testbench.sv
// Self-checking bench for hsl_color_jitter_core: random pixel beats, offset sweeps, stalls.
// Depends on hslj_pkg and the core RTL; expected pixels come from an in-bench HSL model.
`timescale 1ns / 1ps

module testbench;
  import hslj_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = FRAC_BITS + 16;
  localparam int LONG_HOLD    = 300;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [CH_W-1:0]      red_in_i = '0;
  logic [CH_W-1:0]      green_in_i = '0;
  logic [CH_W-1:0]      blue_in_i = '0;
  logic                 last_pixel_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [CH_W-1:0]      red_out_o;
  logic [CH_W-1:0]      green_out_o;
  logic [CH_W-1:0]      blue_out_o;
  logic                 last_out_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_HUE;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  hsl_color_jitter_core u_top (.*);

  pixel_t pending_pixels[$];
  pixel_t expected_pixels[$];

  // shadow copy of the offset registers
  longint hue_shift, sat_shift, light_shift;
  int     mismatches = 0;
  int     pixels_taken = 0;
  logic   in_fire = 1'b0;

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  function automatic longint offset_frac(input longint off);
    if (FRAC_BITS >= 16) return off <<< (FRAC_BITS - 16);
    return off >>> (16 - FRAC_BITS);
  endfunction

  function automatic longint clamp_unit(input longint v);
    longint one;
    one = longint'(1) <<< FRAC_BITS;
    return v < 0 ? 0 : (v > one ? one : v);
  endfunction

  // channel level for a hue position held as three times the fraction
  function automatic longint ramp_level(input longint p, input longint q, input longint t3);
    longint one, half, diff;
    one  = longint'(1) <<< FRAC_BITS;
    half = one >>> 1;
    diff = q - p;
    if (2 * t3 < one) return p + ((diff * 2 * t3 + half) >>> FRAC_BITS);
    if (2 * t3 < 3 * one) return q;
    if (t3 < 2 * one) return p + ((diff * (4 * one - 2 * t3) + half) >>> FRAC_BITS);
    return p;
  endfunction

  function automatic logic [CH_W-1:0] level_to_byte(input longint v);
    longint one, r;
    one = longint'(1) <<< FRAC_BITS;
    r = (clamp_unit(v) * 255 + (one >>> 1)) >>> FRAC_BITS;
    return CH_W'(r > 255 ? 255 : r);
  endfunction

  function automatic pixel_t jitter_pixel(input pixel_t px);
    longint one, r, g, b, mx, mn, sum, d, h, s, l, den, num, ls, q, p, h3, tr, tb;
    longint ro, go, bo;
    pixel_t res;
    one = longint'(1) <<< FRAC_BITS;
    r = px.red; g = px.green; b = px.blue;
    mx = r > g ? r : g;  mx = mx > b ? mx : b;
    mn = r < g ? r : g;  mn = mn < b ? mn : b;
    sum = mx + mn;
    d = mx - mn;
    h = 0;
    s = 0;
    l = (sum * one + 255) / 510;
    if (d != 0) begin
      den = sum <= 255 ? sum : 510 - sum;
      s = (d * one + den / 2) / den;
      if (mx == r) num = g - b + (g < b ? 6 * d : 0);
      else if (mx == g) num = b - r + 2 * d;
      else num = r - g + 4 * d;
      h = (num * one + 3 * d) / (6 * d);
    end
    h = (h + offset_frac(hue_shift)) & (one - 1);
    s = clamp_unit(s + offset_frac(sat_shift));
    l = clamp_unit(l + offset_frac(light_shift));
    if (s == 0) begin
      ro = l; go = l; bo = l;
    end else begin
      ls = (l * s + (one >>> 1)) >>> FRAC_BITS;
      q  = l < (one >>> 1) ? l + ls : l + s - ls;
      p  = 2 * l - q;
      h3 = 3 * h;
      tr = h3 + one;
      tb = h3 - one;
      if (tr >= 3 * one) tr -= 3 * one;
      if (tb < 0) tb += 3 * one;
      ro = ramp_level(p, q, tr);
      go = ramp_level(p, q, h3);
      bo = ramp_level(p, q, tb);
    end
    res.red   = level_to_byte(ro);
    res.green = level_to_byte(go);
    res.blue  = level_to_byte(bo);
    res.last  = px.last;
    return res;
  endfunction

  // Monitor: sample every handshake at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t px, want;
    if (!rst_ni) begin
      hue_shift   <= 0;
      sat_shift   <= 0;
      light_shift <= 0;
      in_fire     <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_HUE:   hue_shift   <= longint'($signed(cfg_data_i));
          CFG_SAT:   sat_shift   <= longint'($signed(cfg_data_i));
          CFG_LIGHT: light_shift <= longint'($signed(cfg_data_i));
          default: ;  // drop writes to the spare index
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        px = '{red_in_i, green_in_i, blue_in_i, last_pixel_i};
        expected_pixels.push_back(jitter_pixel(px));
        pixels_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (red_out_o !== want.red) report_mismatch("red", red_out_o, want.red);
          if (green_out_o !== want.green) report_mismatch("green", green_out_o, want.green);
          if (blue_out_o !== want.blue) report_mismatch("blue", blue_out_o, want.blue);
          if (last_out_o !== want.last) report_mismatch("last", last_out_o, want.last);
        end
      end
    end
  end

  // Driver: bursts of beats with random gaps; hold a beat until it is taken.
  int burst_left = 8;
  int gap_left = 0;
  always @(negedge clk_i) begin
    pixel_t px;
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        px = pending_pixels.pop_front();
        in_valid_i   <= 1'b1;
        red_in_i     <= px.red;
        green_in_i   <= px.green;
        blue_in_i    <= px.blue;
        last_pixel_i <= px.last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: open windows, random stalls, and one long hold-off to back up the pipe.
  int   rx_tick = 0;
  int   hold_left = 0;
  logic long_hold_done = 1'b0;
  always @(negedge clk_i) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && pixels_taken >= 300) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if ((rx_tick % 512) < 128) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_offset(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_pixel(input int r, input int g, input int b, input bit last);
    pending_pixels.push_back('{CH_W'(r), CH_W'(g), CH_W'(b), last});
  endtask

  // Mostly fully random pixels; some near-gray to hit tiny chroma and the gray case.
  task automatic add_random_pixels(input int count);
    int base;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        base = $urandom_range(0, 255);
        add_pixel(base, (base + $urandom_range(0, 2)) % 256,
                  (base + 256 - $urandom_range(0, 2)) % 256, $urandom_range(0, 15) == 0);
      end else begin
        add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 15) == 0);
      end
    end
  endtask

  // Let the pipe drain completely before touching the offsets.
  task automatic drain_pipe();
    wait (pending_pixels.size() == 0 && !in_valid_i && expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [CFG_W-1:0] hue_v, sat_v, light_v;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed pixels at zero offsets: extremes, primaries, gray, sector edges
    add_pixel(0, 0, 0, 0);        add_pixel(255, 255, 255, 1);
    add_pixel(255, 0, 0, 0);      add_pixel(0, 255, 0, 0);
    add_pixel(0, 0, 255, 0);      add_pixel(255, 255, 0, 0);
    add_pixel(0, 255, 255, 0);    add_pixel(255, 0, 255, 0);
    add_pixel(128, 128, 128, 1);  add_pixel(255, 0, 1, 0);
    add_pixel(1, 2, 3, 0);        add_pixel(128, 127, 127, 0);
    add_pixel(200, 55, 100, 0);   add_pixel(170, 85, 0, 1);
    add_pixel(1, 0, 0, 0);        add_pixel(254, 255, 255, 0);
    add_pixel(127, 128, 0, 0);    add_pixel(85, 170, 255, 1);
    drain_pipe();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin hue_v = 18'sd65536;  sat_v = -18'sd65536; light_v = 18'sd0;      end
        1: begin hue_v = -18'sd65536; sat_v = 18'sd65536;  light_v = 18'sd65536;  end
        2: begin hue_v = 18'sd21845;  sat_v = 18'sd0;      light_v = -18'sd65536; end
        3: begin hue_v = 18'h1FFFF;   sat_v = 18'h20000;   light_v = 18'h1FFFF;   end
        4: begin hue_v = 18'h20000;   sat_v = 18'h1FFFF;   light_v = 18'h20000;   end
        5: begin hue_v = -18'sd1;     sat_v = 18'sd1;      light_v = -18'sd1;     end
        default: begin
          hue_v   = 18'($signed($urandom_range(0, 131072)) - 65536);
          sat_v   = 18'($signed($urandom_range(0, 131072)) - 65536);
          light_v = 18'($signed($urandom_range(0, 65536)) - 32768);
        end
      endcase
      write_offset(CFG_HUE, hue_v);
      write_offset(CFG_SAT, sat_v);
      write_offset(CFG_LIGHT, light_v);
      if (phase == 1) write_offset(CFG_IDX_W'(3), 18'h15555);  // spare index, dropped
      add_random_pixels(phase < 6 ? 150 : 250);
      drain_pipe();
    end

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
